FILE: sv/qesa_pkg.sv
// qesa_pkg: shared types, constants and helpers of the quadrature encoder speed/angle core
// no dependencies; imported by every module of the core

package qesa_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int ACC_WIDTH_DEF   = 32;
	localparam int QUEUE_DEPTH     = 4;

	localparam int CPR_W      = 16;
	localparam int GAIN_W     = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	localparam int ANGLE_W = 17;
	localparam int REL_W   = 32;
	localparam int RPM_W   = 24;
	localparam int DELTA_W = 17;

	localparam int MAG_W  = 32;
	localparam int PROD_W = 2 * MAG_W;
	localparam int RND_W  = PROD_W - 16;

	localparam int ANGLE_LIMIT = 46080;
	localparam int DELTA_LIMIT = 65535;

	localparam logic [CPR_W-1:0]  CPR_RESET        = 16'd1560;
	localparam logic [GAIN_W-1:0] ANGLE_GAIN_RESET = 32'd3871665;
	localparam logic [GAIN_W-1:0] RPM_GAIN_RESET   = 32'd64527754;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COUNTS_PER_REV = 2'd0,
		REG_ANGLE_GAIN     = 2'd1,
		REG_RPM_GAIN       = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		WRAP_NONE  = 2'd0,
		WRAP_PLUS  = 2'd1,
		WRAP_MINUS = 2'd2
	} wrap_t;

	typedef struct packed {
		logic [CPR_W-1:0]  counts_per_rev;
		logic [GAIN_W-1:0] angle_gain;
		logic [GAIN_W-1:0] rpm_gain;
	} cfg_t;

	// position of code {a,b} in the up sequence 00, 10, 11, 01
	function automatic logic [1:0] gray_pos(input logic [1:0] code);
		logic [1:0] pos;
		unique case (code)
			2'b00: pos = 2'd0;
			2'b01: pos = 2'd3;
			2'b10: pos = 2'd1;
			2'b11: pos = 2'd2;
			default: pos = 2'd0;
		endcase
		return pos;
	endfunction

endpackage

FILE: sv/quadrature_encoder_speed_angle_core.sv
// Quadrature encoder x4 channel with angle and speed output. One input item is taken every
// clock cycle while in_stall is low: the position counter in the front updates on each accepted pin sample.
// An update tick leaves its job in a four-entry queue, from which the scaling pipeline
// takes it (magnitude, three 32x32 multiplies, rounding, saturation and accumulation).
// in_stall rises only when four ticks wait in the queue behind a stalled result; pin
// samples pass the front at one per cycle otherwise.
// Depends on qesa_pkg, qesa_front, qesa_fifo and qesa_back.

module quadrature_encoder_speed_angle_core #(
	parameter int COUNT_WIDTH = qesa_pkg::COUNT_WIDTH_DEF,
	parameter int ACC_WIDTH   = qesa_pkg::ACC_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [qesa_pkg::CFG_IDX_W-1:0]         wr_index,
	input  logic [qesa_pkg::CFG_DATA_W-1:0]        wr_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   op,
	input  logic                                   pin_a,
	input  logic                                   pin_b,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [qesa_pkg::ANGLE_W-1:0]    angle_q8,
	output logic signed [qesa_pkg::REL_W-1:0]      rel_angle_q8,
	output logic signed [qesa_pkg::RPM_W-1:0]      rpm_q8,
	output logic signed [qesa_pkg::DELTA_W-1:0]    count_delta
);
	import qesa_pkg::*;

	localparam int JW = 2 * COUNT_WIDTH + 3;
	localparam int LW = $clog2(QUEUE_DEPTH + 1);

	cfg_t           cfg_q;
	logic           push;
	logic           pop;
	logic [JW-1:0]  job_in;
	logic [JW-1:0]  job_out;
	logic           q_empty;
	logic           q_full;
	logic [LW-1:0]  q_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.counts_per_rev <= CPR_RESET;
			cfg_q.angle_gain     <= ANGLE_GAIN_RESET;
			cfg_q.rpm_gain       <= RPM_GAIN_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_COUNTS_PER_REV: cfg_q.counts_per_rev <= wr_data[CPR_W-1:0];
				REG_ANGLE_GAIN:     cfg_q.angle_gain     <= wr_data[GAIN_W-1:0];
				REG_RPM_GAIN:       cfg_q.rpm_gain       <= wr_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	qesa_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op      (op),
		.pin_a   (pin_a),
		.pin_b   (pin_b),
		.cfg     (cfg_q),
		.full    (q_full),
		.push    (push),
		.job     (job_in)
	);

	qesa_fifo #(
		.WIDTH(JW),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (job_in),
		.pop   (pop),
		.rdata (job_out),
		.empty (q_empty),
		.full  (q_full),
		.level (q_level)
	);

	qesa_back #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.ACC_WIDTH  (ACC_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (!q_empty),
		.job         (job_out),
		.pop         (pop),
		.cfg         (cfg_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.angle_q8    (angle_q8),
		.rel_angle_q8(rel_angle_q8),
		.rpm_q8      (rpm_q8),
		.count_delta (count_delta)
	);

	// queue occupancy bounded
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= LW'(QUEUE_DEPTH))
		else $error("queue level above depth");

	// pin samples never enter the queue
	a_sample_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !op) |=> (q_level <= $past(q_level)))
		else $error("pin sample pushed a job");

	// no motion means no speed
	a_zero_delta: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && count_delta == '0) |-> (rpm_q8 == '0))
		else $error("speed without count change");

	// saturated fields stay in range
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (angle_q8 <= 17'sd46080 && angle_q8 >= -17'sd46080
			&& count_delta != {1'b1, {(DELTA_W-1){1'b0}}}))
		else $error("result field out of range");

endmodule

FILE: sv/qesa_front.sv
// qesa_front: pin decoding, wrapping position counter and tick classification
// uses qesa_pkg; pushes one job per update tick into the queue

module qesa_front #(
	parameter int COUNT_WIDTH = qesa_pkg::COUNT_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       op,
	input  logic                       pin_a,
	input  logic                       pin_b,
	input  qesa_pkg::cfg_t             cfg,
	input  logic                       full,
	output logic                       push,
	output logic [2*COUNT_WIDTH+2:0]   job
);
	import qesa_pkg::*;

	localparam int CW = COUNT_WIDTH;
	localparam int MW = CW + 1;
	localparam int DW = CW + 2;
	localparam logic [MW-1:0] FULL_M = MW'(1) << CW;
	localparam longint unsigned FULL_L = 64'd1 << CW;
	localparam longint unsigned RST_M =
		(CPR_RESET == '0 || 64'(CPR_RESET) > FULL_L) ? FULL_L : 64'(CPR_RESET);
	localparam logic [CW-1:0] RST_HALF = CW'(RST_M / 2);
	localparam logic [1:0] STEP_UP   = 2'd1;
	localparam logic [1:0] STEP_DOWN = 2'd3;

	logic [1:0]        prev_pins_q;
	logic [CW-1:0]     pulse_q;
	logic [CW-1:0]     last_q;
	wrap_t             wrap_q;

	logic              accept;
	logic [1:0]        cur;
	logic [1:0]        step;
	logic [MW-1:0]     m;
	logic [MW-1:0]     m_less1;
	logic signed [DW-1:0] corr;
	logic signed [DW-1:0] delta;
	logic signed [MW-1:0] ang_off;

	always_comb begin
		m = (cfg.counts_per_rev == '0 || 33'(cfg.counts_per_rev) > 33'(FULL_M))
			? FULL_M : MW'(cfg.counts_per_rev);
		m_less1 = m - MW'(1);
		cur = {pin_a, pin_b};
		step = gray_pos(cur) - gray_pos(prev_pins_q);
		unique case (wrap_q)
			WRAP_PLUS:  corr = $signed(DW'(m));
			WRAP_MINUS: corr = -$signed(DW'(m));
			default:    corr = '0;
		endcase
		delta = $signed(DW'(pulse_q)) - $signed(DW'(last_q)) + corr;
		ang_off = $signed(MW'(pulse_q)) - $signed(m >> 1);
	end

	assign in_stall = full;
	assign accept   = in_valid && !full;
	assign push     = accept && op;
	assign job      = {delta, ang_off};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pins_q <= '0;
			pulse_q     <= RST_HALF;
			last_q      <= RST_HALF;
			wrap_q      <= WRAP_NONE;
		end else if (accept) begin
			if (!op) begin
				prev_pins_q <= cur;
				if (step == STEP_UP) begin
					if (MW'(pulse_q) >= m_less1) begin
						pulse_q <= '0;
						wrap_q  <= WRAP_PLUS;
					end else begin
						pulse_q <= pulse_q + CW'(1);
					end
				end else if (step == STEP_DOWN) begin
					if (pulse_q == '0) begin
						pulse_q <= CW'(m_less1);
						wrap_q  <= WRAP_MINUS;
					end else begin
						pulse_q <= pulse_q - CW'(1);
					end
				end
			end else begin
				last_q <= pulse_q;
				wrap_q <= WRAP_NONE;
			end
		end
	end

endmodule

FILE: sv/qesa_fifo.sv
// qesa_fifo: small register queue of tick jobs between front and back
// uses qesa_pkg for the default queue depth

module qesa_fifo #(
	parameter int WIDTH = 35,
	parameter int DEPTH = qesa_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [WIDTH-1:0]               wdata,
	input  logic                           pop,
	output logic [WIDTH-1:0]               rdata,
	output logic                           empty,
	output logic                           full,
	output logic [$clog2(DEPTH+1)-1:0]     level
);
	import qesa_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [LW-1:0]    level_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign rdata = mem_q[rd_ptr_q];
	assign empty = (level_q == '0);
	assign full  = (level_q == LW'(DEPTH));
	assign level = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				level_q <= level_q + LW'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LW'(1);
			end
		end
	end

endmodule

FILE: sv/qesa_back.sv
// qesa_back: scaling pipeline for tick jobs, relative angle accumulator, result register
// uses qesa_pkg; pops jobs from the queue and drives the result channel

module qesa_back #(
	parameter int COUNT_WIDTH = qesa_pkg::COUNT_WIDTH_DEF,
	parameter int ACC_WIDTH   = qesa_pkg::ACC_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   job_valid,
	input  logic [2*COUNT_WIDTH+2:0]               job,
	output logic                                   pop,
	input  qesa_pkg::cfg_t                         cfg,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [qesa_pkg::ANGLE_W-1:0]    angle_q8,
	output logic signed [qesa_pkg::REL_W-1:0]      rel_angle_q8,
	output logic signed [qesa_pkg::RPM_W-1:0]      rpm_q8,
	output logic signed [qesa_pkg::DELTA_W-1:0]    count_delta
);
	import qesa_pkg::*;

	localparam int CW   = COUNT_WIDTH;
	localparam int MW   = CW + 1;
	localparam int DW   = CW + 2;
	localparam int JW   = DW + MW;
	localparam int SUMW = (ACC_WIDTH > RND_W + 1) ? ACC_WIDTH + 1 : RND_W + 2;
	localparam logic [MAG_W-1:0] MAG_MAX = '1;
	localparam logic signed [SUMW-1:0] ACC_MAX =
		SUMW'((64'd1 << (ACC_WIDTH - 1)) - 64'd1);
	localparam logic signed [SUMW-1:0] ACC_MIN = -ACC_MAX - 1;
	localparam logic [RPM_W-1:0] RPM_POS_LIM = {1'b0, {(RPM_W-1){1'b1}}};
	localparam logic [RPM_W-1:0] RPM_NEG_LIM = {1'b1, {(RPM_W-1){1'b0}}};

	logic adv;

	// stage 1: magnitudes
	logic                    s1_valid;
	logic                    d_sign_s1;
	logic                    a_sign_s1;
	logic [MAG_W-1:0]        d_mag_s1;
	logic [MAG_W-1:0]        a_mag_s1;
	logic signed [DELTA_W-1:0] cd_s1;

	// stage 2: products
	logic                    s2_valid;
	logic                    d_sign_s2;
	logic                    a_sign_s2;
	logic [PROD_W-1:0]       ang_prod_s2;
	logic [PROD_W-1:0]       rel_prod_s2;
	logic [PROD_W-1:0]       rpm_prod_s2;
	logic signed [DELTA_W-1:0] cd_s2;

	// stage 3: rounded magnitudes
	logic                    s3_valid;
	logic                    d_sign_s3;
	logic                    a_sign_s3;
	logic [RND_W-1:0]        ang_p_s3;
	logic [RND_W-1:0]        rel_p_s3;
	logic [RND_W-1:0]        rpm_p_s3;
	logic signed [DELTA_W-1:0] cd_s3;

	logic signed [ACC_WIDTH-1:0] acc_q;
	logic                        out_valid_q;

	logic signed [DW-1:0]     delta;
	logic signed [MW-1:0]     ang_off;
	logic [DW-1:0]            d_abs;
	logic [MW-1:0]            a_abs;
	logic signed [63:0]       dl;
	logic signed [DELTA_W-1:0] cd;

	logic [ANGLE_W-1:0]        ang_mag;
	logic signed [ANGLE_W-1:0] ang_val;
	logic [RPM_W-1:0]          rpm_lim;
	logic [RPM_W-1:0]          rpm_mag;
	logic signed [RPM_W-1:0]   rpm_val;
	logic signed [RND_W:0]     rel_step;
	logic signed [SUMW-1:0]    sum;
	logic signed [ACC_WIDTH-1:0] acc_next;
	logic signed [63:0]        r64;
	logic signed [REL_W-1:0]   rel_val;

	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && job_valid;

	always_comb begin
		delta   = $signed(job[JW-1 -: DW]);
		ang_off = $signed(job[MW-1:0]);
		d_abs   = delta[DW-1] ? DW'(-delta) : DW'(delta);
		a_abs   = ang_off[MW-1] ? MW'(-ang_off) : MW'(ang_off);
		dl      = 64'(delta);
		if (dl > 64'sd65535) begin
			cd = DELTA_W'(DELTA_LIMIT);
		end else if (dl < -64'sd65535) begin
			cd = -DELTA_W'(DELTA_LIMIT);
		end else begin
			cd = DELTA_W'(dl);
		end
	end

	always_comb begin
		ang_mag = (ang_p_s3 > RND_W'(ANGLE_LIMIT)) ? ANGLE_W'(ANGLE_LIMIT)
			: ANGLE_W'(ang_p_s3);
		ang_val = a_sign_s3 ? -$signed(ang_mag) : $signed(ang_mag);

		rpm_lim = d_sign_s3 ? RPM_NEG_LIM : RPM_POS_LIM;
		rpm_mag = (rpm_p_s3 > RND_W'(rpm_lim)) ? rpm_lim : RPM_W'(rpm_p_s3);
		rpm_val = d_sign_s3 ? -$signed(rpm_mag) : $signed(rpm_mag);

		rel_step = d_sign_s3 ? -$signed({1'b0, rel_p_s3}) : $signed({1'b0, rel_p_s3});
		sum = SUMW'(acc_q) + SUMW'(rel_step);
		if (sum > ACC_MAX) begin
			acc_next = ACC_WIDTH'(ACC_MAX);
		end else if (sum < ACC_MIN) begin
			acc_next = ACC_WIDTH'(ACC_MIN);
		end else begin
			acc_next = ACC_WIDTH'(sum);
		end
		r64 = 64'(acc_next);
		if (r64 > 64'sd2147483647) begin
			rel_val = {1'b0, {(REL_W-1){1'b1}}};
		end else if (r64 < -64'sd2147483648) begin
			rel_val = {1'b1, {(REL_W-1){1'b0}}};
		end else begin
			rel_val = REL_W'(r64);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			s2_valid    <= 1'b0;
			s3_valid    <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
		end else if (adv) begin
			s1_valid    <= job_valid;
			s2_valid    <= s1_valid;
			s3_valid    <= s2_valid;
			out_valid_q <= s3_valid;
			if (s3_valid) begin
				acc_q <= acc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_sign_s1 <= delta[DW-1];
			a_sign_s1 <= ang_off[MW-1];
			d_mag_s1  <= (64'(d_abs) > 64'(MAG_MAX)) ? MAG_MAX : MAG_W'(d_abs);
			a_mag_s1  <= MAG_W'(a_abs);
			cd_s1     <= cd;

			d_sign_s2   <= d_sign_s1;
			a_sign_s2   <= a_sign_s1;
			ang_prod_s2 <= PROD_W'(a_mag_s1) * PROD_W'(cfg.angle_gain);
			rel_prod_s2 <= PROD_W'(d_mag_s1) * PROD_W'(cfg.angle_gain);
			rpm_prod_s2 <= PROD_W'(d_mag_s1) * PROD_W'(cfg.rpm_gain);
			cd_s2       <= cd_s1;

			// round to nearest, ties away from zero on the magnitude
			d_sign_s3 <= d_sign_s2;
			a_sign_s3 <= a_sign_s2;
			ang_p_s3  <= RND_W'((ang_prod_s2 + PROD_W'(32768)) >> 16);
			rel_p_s3  <= RND_W'((rel_prod_s2 + PROD_W'(32768)) >> 16);
			rpm_p_s3  <= RND_W'((rpm_prod_s2 + PROD_W'(32768)) >> 16);
			cd_s3     <= cd_s2;

			if (s3_valid) begin
				angle_q8     <= ang_val;
				rel_angle_q8 <= rel_val;
				rpm_q8       <= rpm_val;
				count_delta  <= cd_s3;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: tb/testbench.sv
// testbench for quadrature_encoder_speed_angle_core: pin samples and update ticks go in,
// a scoreboard class predicts each reading and checks it; needs qesa_pkg and the core

`timescale 1ns / 1ps

module testbench;
	import qesa_pkg::*;

	localparam int COUNT_W = COUNT_WIDTH_DEF;
	localparam int ACC_W = ACC_WIDTH_DEF;
	localparam int CPR_PAD = CFG_DATA_W - CPR_W;
	localparam int LATENCY = 4;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic OP_PINS = 1'b0;
	localparam logic OP_TICK = 1'b1;
	localparam logic [1:0] MOVE_HOLD = 2'd0;
	localparam logic [1:0] MOVE_UP = 2'd1;
	localparam logic [1:0] MOVE_JUMP = 2'd2;
	localparam logic [1:0] MOVE_DOWN = 2'd3;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle;
		logic signed [REL_W-1:0] rel;
		logic signed [RPM_W-1:0] rpm;
		logic signed [DELTA_W-1:0] delta;
	} reading_t;

	class EncoderTracker;
		logic [CPR_W-1:0] cpr;
		logic [GAIN_W-1:0] angle_gain;
		logic [GAIN_W-1:0] rpm_gain;
		logic [1:0] pins;
		logic [COUNT_W-1:0] count;
		logic [COUNT_W-1:0] count_at_tick;
		wrap_t wrap;
		longint rel_acc;
		reading_t readings_due[$];
		int errors;

		function new();
			cpr = CPR_RESET;
			angle_gain = ANGLE_GAIN_RESET;
			rpm_gain = RPM_GAIN_RESET;
			pins = 2'b00;
			count = COUNT_W'(modulus() / 2);
			count_at_tick = count;
			wrap = WRAP_NONE;
			rel_acc = 0;
			errors = 0;
		endfunction

		function longint modulus();
			return (cpr == 0) ? (longint'(1) << COUNT_W) : longint'(cpr);
		endfunction

		function logic [1:0] pos_of(logic [1:0] code);
			case (code)
				2'b00: return 2'd0;
				2'b10: return 2'd1;
				2'b11: return 2'd2;
				default: return 2'd3;
			endcase
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		// round(v * g / 2^16), ties away from zero
		function longint scale_q16(longint v, logic [GAIN_W-1:0] g);
			longint unsigned mag;
			longint unsigned p;
			mag = (v < 0) ? -v : v;
			p = (mag * {32'd0, g} + 64'd32768) >> 16;
			return (v < 0) ? -longint'(p) : longint'(p);
		endfunction

		function void step_pins(logic a, logic b);
			logic [1:0] now;
			logic [1:0] step;
			longint m;
			now = {a, b};
			step = pos_of(now) - pos_of(pins);
			m = modulus();
			pins = now;
			if (step == MOVE_UP) begin
				if (longint'(count) >= m - 1) begin
					count = '0;
					wrap = WRAP_PLUS;
				end else begin
					count = count + 1'b1;
				end
			end else if (step == MOVE_DOWN) begin
				if (count == 0) begin
					count = COUNT_W'(m - 1);
					wrap = WRAP_MINUS;
				end else begin
					count = count - 1'b1;
				end
			end
		endfunction

		function void predict_tick();
			longint m;
			longint delta;
			longint d;
			longint ang;
			longint rel;
			longint rpm;
			longint amax;
			reading_t r;
			m = modulus();
			delta = longint'(count) - longint'(count_at_tick);
			if (wrap == WRAP_PLUS)
				delta = delta + m;
			else if (wrap == WRAP_MINUS)
				delta = delta - m;
			d = clamp(delta, -64'sd4294967295, 64'sd4294967295);
			ang = clamp(scale_q16(longint'(count) - m / 2, angle_gain), -ANGLE_LIMIT, ANGLE_LIMIT);
			amax = (longint'(1) << (ACC_W - 1)) - 1;
			rel_acc = clamp(rel_acc + scale_q16(d, angle_gain), -amax - 1, amax);
			rel = clamp(rel_acc, -64'sd2147483648, 64'sd2147483647);
			rpm = clamp(scale_q16(d, rpm_gain), -64'sd8388608, 64'sd8388607);
			r.angle = ANGLE_W'(ang);
			r.rel = REL_W'(rel);
			r.rpm = RPM_W'(rpm);
			r.delta = DELTA_W'(clamp(delta, -DELTA_LIMIT, DELTA_LIMIT));
			readings_due.push_back(r);
			count_at_tick = count;
			wrap = WRAP_NONE;
		endfunction

		function void take_item(logic o, logic a, logic b);
			if (o == OP_TICK)
				predict_tick();
			else
				step_pins(a, b);
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_COUNTS_PER_REV: cpr = data[CPR_W-1:0];
				REG_ANGLE_GAIN: angle_gain = data;
				REG_RPM_GAIN: rpm_gain = data;
				default: ;
			endcase
		endfunction

		function void check_reading(reading_t got);
			reading_t want;
			if (readings_due.size() == 0) begin
				$error("reading transfer with none expected");
				errors++;
				return;
			end
			want = readings_due.pop_front();
			if (got.angle !== want.angle) begin
				$error("angle_q8 expected %0d got %0d", want.angle, got.angle);
				errors++;
			end
			if (got.rel !== want.rel) begin
				$error("rel_angle_q8 expected %0d got %0d", want.rel, got.rel);
				errors++;
			end
			if (got.rpm !== want.rpm) begin
				$error("rpm_q8 expected %0d got %0d", want.rpm, got.rpm);
				errors++;
			end
			if (got.delta !== want.delta) begin
				$error("count_delta expected %0d got %0d", want.delta, got.delta);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = 1'b0;
	logic pin_a = 1'b0;
	logic pin_b = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [ANGLE_W-1:0] angle_q8;
	logic signed [REL_W-1:0] rel_angle_q8;
	logic signed [RPM_W-1:0] rpm_q8;
	logic signed [DELTA_W-1:0] count_delta;

	EncoderTracker tracker;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_kick = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycles = 0;
	logic [1:0] pin_pos = 2'd0;
	logic [1:0] run_dir = MOVE_UP;

	quadrature_encoder_speed_angle_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.pin_a(pin_a),
		.pin_b(pin_b),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.angle_q8(angle_q8),
		.rel_angle_q8(rel_angle_q8),
		.rpm_q8(rpm_q8),
		.count_delta(count_delta)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("quadrature_encoder_speed_angle_core verification failed");
			$finish;
		end
	end

	// reading side: check each transfer, then pick the next stall
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			tracker.check_reading({angle_q8, rel_angle_q8, rpm_q8, count_delta});
		if (hold_kick != hold_seen) begin
			hold_seen = hold_kick;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0)
			hold_left--;
		out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
	end

	function automatic logic [1:0] code_at(logic [1:0] p);
		case (p)
			2'd0: return 2'b00;
			2'd1: return 2'b10;
			2'd2: return 2'b11;
			default: return 2'b01;
		endcase
	endfunction

	task automatic offer(logic o, logic a, logic b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		pin_a <= a;
		pin_b <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.take_item(o, a, b);
	endtask

	task automatic pin_move(logic [1:0] shift);
		logic [1:0] code;
		pin_pos = pin_pos + shift;
		code = code_at(pin_pos);
		offer(OP_PINS, code[1], code[0]);
	endtask

	task automatic tick();
		offer(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.readings_due.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		tracker.set_register(idx, data);
	endtask

	task automatic set_registers(logic [CPR_W-1:0] cpr, logic [GAIN_W-1:0] ag,
			logic [GAIN_W-1:0] rg);
		write_reg(REG_COUNTS_PER_REV, {CPR_PAD'($urandom), cpr});
		write_reg(REG_ANGLE_GAIN, ag);
		write_reg(REG_RPM_GAIN, rg);
		write_reg(REG_UNUSED, $urandom);
		wr_en <= 1'b0;
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return $urandom_range(0, 32'h0100_0000);
		endcase
	endfunction

	task automatic random_registers();
		logic [CPR_W-1:0] cpr;
		case ($urandom_range(9))
			0: cpr = '0;
			1: cpr = '1;
			2: cpr = CPR_W'($urandom_range(65535));
			default: cpr = CPR_W'($urandom_range(1, 64));
		endcase
		set_registers(cpr, pick_gain(), pick_gain());
	endtask

	task automatic random_item(int tick_pct);
		int r;
		r = $urandom_range(99);
		if (r < tick_pct) begin
			tick();
		end else if (r < tick_pct + 4) begin
			pin_move(MOVE_JUMP);
		end else if (r < tick_pct + 12) begin
			pin_move(MOVE_HOLD);
		end else if (r < tick_pct + 16) begin
			pin_move(2'($urandom_range(3)));
		end else begin
			if ($urandom_range(99) < 6)
				run_dir = (run_dir == MOVE_UP) ? MOVE_DOWN : MOVE_UP;
			pin_move(run_dir);
		end
	endtask

	initial begin
		tracker = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: still tick, a full cycle up, steps down, both pins changing
		tick();
		repeat (4) pin_move(MOVE_UP);
		tick();
		repeat (3) pin_move(MOVE_DOWN);
		tick();
		pin_move(MOVE_JUMP);
		tick();

		// small modulus below the count, full gains: wraps both ways, last wrap wins
		settle();
		set_registers(16'd4, '1, '1);
		repeat (2) pin_move(MOVE_UP);
		tick();
		repeat (2) pin_move(MOVE_DOWN);
		tick();
		pin_move(MOVE_UP);
		pin_move(MOVE_DOWN);
		tick();

		// zero modulus means full range, zero gains
		settle();
		set_registers('0, '0, '0);
		pin_move(MOVE_UP);
		tick();

		// long receiver hold-off while ticks keep coming
		settle();
		set_registers(CPR_RESET, ANGLE_GAIN_RESET, RPM_GAIN_RESET);
		hold_kick++;
		repeat (40) random_item(45);

		for (int seg = 0; seg < 6; seg++) begin
			settle();
			case (seg / 2)
				0: begin
					send_idle_pct = 31;
					recv_idle_pct = 65;
				end
				1: begin
					send_idle_pct = 65;
					recv_idle_pct = 31;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			random_registers();
			repeat (150) random_item(9);
		end
		settle();

		if (tracker.errors == 0 && tracker.readings_due.size() == 0)
			$display("quadrature_encoder_speed_angle_core verification clean");
		else
			$display("quadrature_encoder_speed_angle_core verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
sv/qesa_pkg.sv
sv/qesa_front.sv
sv/qesa_fifo.sv
sv/qesa_back.sv
sv/quadrature_encoder_speed_angle_core.sv
tb/testbench.sv
